@@ rtl/tapc_pkg.sv @@
// ----------------------------------------------------------------------------
// tapc_pkg: shared types and constants of the thrust and attitude controller
// Holds the sequencer state type, register indexes, mode codes and widths.
// ----------------------------------------------------------------------------
package tapc_pkg;

	// Signed width of wide intermediates, and their saturation bound.
	localparam int WIDE_W = 64;
	localparam logic [63:0] WIDE_MAX = 64'h3FFF_FFFF_FFFF_FFFF;
	// Bits of a wide magnitude.
	localparam int MAG_W = 62;
	// Widest multiplier operand b, and the full product width.
	localparam int MB_W = 28;
	localparam int PROD_W = MAG_W + MB_W;
	// Fraction bits of the sample period.
	localparam int PERIOD_BITS = 16;

	// Configuration register indexes.
	localparam logic [2:0] REG_THRUST_KP = 3'd0;
	localparam logic [2:0] REG_THRUST_KI = 3'd1;
	localparam logic [2:0] REG_ANGLE_KP = 3'd2;
	localparam logic [2:0] REG_ANGLE_KI = 3'd3;
	localparam logic [2:0] REG_PERIOD = 3'd4;
	localparam logic [2:0] REG_GRAVITY = 3'd5;
	localparam logic [2:0] REG_THRUST_LIM = 3'd6;
	localparam logic [2:0] REG_ANGLE_LIM = 3'd7;

	// Mode commands.
	localparam logic [1:0] ACT_AUTO_ON = 2'd1;
	localparam logic [1:0] ACT_AUTO_OFF = 2'd2;

	// Multiplier step codes.
	localparam logic [2:0] STEP_LIFT = 3'd0;
	localparam logic [2:0] STEP_VINT = 3'd1;
	localparam logic [2:0] STEP_PERIOD = 3'd2;
	localparam logic [2:0] STEP_MASS = 3'd3;
	localparam logic [2:0] STEP_APROP = 3'd4;
	localparam logic [2:0] STEP_AINT = 3'd5;
	localparam logic [2:0] STEP_RANGE = 3'd6;

	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_PREP = 6'b000010,
		ST_MUL  = 6'b000100,
		ST_DIV  = 6'b001000,
		ST_FIN  = 6'b010000,
		ST_DONE = 6'b100000
	} state_t;

endpackage

@@ rtl/thrust_attitude_pi_controller.sv @@
// ----------------------------------------------------------------------------
// thrust_attitude_pi_controller: thrust and pitch PI controller
// Fixed point PI control of thrust and pitch angle with anti-windup.
// ----------------------------------------------------------------------------
// Usage. One sample arrives per transaction on the s_axis channel and gives
// exactly one result transaction on the m_axis channel. Gains, gravity, the
// sample period and the output limits sit in registers written over the cfg
// channel, which is always ready; write them only while the block is idle.
//
// Sequence. In manual mode the prep state forms the clamped result and the
// done state loads it to the output. In autopilot mode the prep state forms
// the errors, then seven products, each built from two partial products,
// run on one shared 32 by 28 bit multiplier, then a restoring divider forms
// 13 + FRAC_BITS quotient bits, then the angle is clamped and the done state
// loads the output. A zero divisor skips the range product and the divider;
// an integer quotient beyond the angle limit skips the divider. The done
// state waits while an unaccepted result holds the output register.
// s_axis_tready is high only while the sequencer is idle, which it enters as
// the result is loaded, so a new sample is not taken before the last is done.
//
// Reset puts the configuration and sequencer registers at their reset values,
// clears both error sums and turns autopilot on. The result waits in an output
// register: a new sample is accepted while it waits, and if that sample
// finishes first, the sequencer holds until the receiver takes the old result.
// ----------------------------------------------------------------------------
module thrust_attitude_pi_controller
	import tapc_pkg::*;
#(
	parameter int FRAC_BITS = 12,
	parameter int SUM_WIDTH = 40
) (
	input  logic         clk,
	input  logic         arst_n,
	// Sample channel.
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// ref_horizontal[31:0], ref_vertical[63:32], mass_kg[91:64],
	// vel_horizontal[123:92], vel_vertical[155:124], zero fill up to 159
	input  logic [159:0] s_axis_tdata,
	// action[1:0]
	input  logic [1:0]   s_axis_tuser,
	// Result channel.
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// thrust_out[27:0], angle_out[41:28], zero fill up to 47
	output logic [47:0]  m_axis_tdata,
	// autopilot_on[0]
	output logic         m_axis_tuser,
	// Configuration write channel.
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [2:0]   cfg_index,
	input  logic [27:0]  cfg_data
);

	// Quotient bits: the integer part is below 2^13 once the range check passes.
	localparam int QB = 13 + FRAC_BITS;
	localparam int CNT_W = $clog2(QB);
	localparam int DIV_W = MAG_W + QB + 1;
	localparam logic [64:0] SUM_LIM = (SUM_WIDTH > 63) ? 65'(WIDE_MAX) :
		((65'd1 << (SUM_WIDTH - 1)) - 65'd1);

	// Configuration registers.
	logic [19:0] kp_t_q, ki_t_q, kp_a_q, ki_a_q, grav_q;
	logic [15:0] period_q;
	logic [27:0] tlim_q;
	logic [12:0] alim_q;

	// Sample and controller state.
	state_t state_q;
	logic mode_q;
	logic signed [31:0] rh_q, rv_q, vh_q, vv_q;
	logic [27:0] mass_q;
	logic signed [32:0] ex_q, ez_q;
	logic signed [SUM_WIDTH-1:0] vsum_q, hsum_q;
	logic signed [63:0] lift_q, tmp_q, num_q;
	logic [MAG_W-1:0] den_q, nmag_q;
	logic [2:0] step_q;
	logic [1:0] ph_q;
	logic [PROD_W-1:0] acc_q;
	logic [DIV_W-1:0] rem_q, dsh_q;
	logic [QB-1:0] quo_q;
	logic [CNT_W-1:0] cnt_q;
	logic [27:0] thrust_q;
	logic signed [13:0] angle_q;
	logic out_valid_q;
	logic [27:0] out_thrust_q;
	logic [13:0] out_angle_q;
	logic out_auto_q;

	function automatic logic signed [63:0] wclamp(input logic signed [64:0] a);
		logic signed [64:0] lim;
		lim = $signed(65'(WIDE_MAX));
		if (a > lim) begin
			return $signed(WIDE_MAX);
		end else if (a < -lim) begin
			return -$signed(WIDE_MAX);
		end
		return 64'(a);
	endfunction

	function automatic logic signed [SUM_WIDTH-1:0] sum_add(
		input logic signed [SUM_WIDTH-1:0] s,
		input logic signed [32:0] e
	);
		logic signed [64:0] t;
		logic signed [64:0] lim;
		t = 65'(s) + 65'(e);
		lim = $signed(SUM_LIM);
		if (t > lim) begin
			t = lim;
		end else if (t < -lim) begin
			t = -lim;
		end
		return SUM_WIDTH'(t);
	endfunction

	// ------------------------------------------------------------------
	// Shared multiplier: operand selection, split product and the
	// saturating floor shift that follows it.
	// ------------------------------------------------------------------
	logic signed [63:0] a_op;
	logic [MB_W-1:0] b_op;
	logic [4:0] sh;
	logic a_neg;
	logic [MAG_W-1:0] a_mag;
	logic [31:0] mul_a;
	logic [59:0] mul_p;
	logic [MAG_W-1:0] pm;
	logic [62:0] mask, rnd, shm;
	logic signed [63:0] mres;

	always_comb begin
		case (step_q)
			STEP_LIFT:   begin a_op = 64'(ez_q);   b_op = MB_W'(kp_t_q);   end
			STEP_VINT:   begin a_op = 64'(vsum_q); b_op = MB_W'(ki_t_q);   end
			STEP_PERIOD: begin a_op = tmp_q;       b_op = MB_W'(period_q); end
			STEP_MASS:   begin a_op = tmp_q;       b_op = mass_q;          end
			STEP_APROP:  begin a_op = 64'(ex_q);   b_op = MB_W'(kp_a_q);   end
			STEP_AINT:   begin a_op = 64'(hsum_q); b_op = MB_W'(ki_a_q);   end
			STEP_RANGE:  begin a_op = 64'(den_q);  b_op = MB_W'(alim_q) + 28'd1; end
			default:     begin a_op = '0;          b_op = '0;              end
		endcase
		sh = (step_q == STEP_PERIOD) ? 5'(PERIOD_BITS) : 5'(FRAC_BITS);
		a_neg = a_op[63];
		a_mag = MAG_W'(a_neg ? -a_op : a_op);
		mul_a = (ph_q == 2'd0) ? a_mag[31:0] : {2'b00, a_mag[MAG_W-1:32]};
		mul_p = mul_a * b_op;
		pm = (|acc_q[PROD_W-1:MAG_W]) ? WIDE_MAX[MAG_W-1:0] : acc_q[MAG_W-1:0];
		mask = (63'd1 << sh) - 63'd1;
		rnd = a_neg ? (63'(pm) + mask) : 63'(pm);
		shm = rnd >> sh;
		mres = a_neg ? -$signed(64'(shm)) : $signed(64'(shm));
	end

	// Results of the step that finishes in this cycle.
	logic signed [63:0] sum_next, num_next;
	logic signed [64:0] tl;
	logic [MAG_W-1:0] lift_mag, num_mag;
	logic div_ge;
	logic [13:0] angle_lim_pos, angle_lim_neg;

	always_comb begin
		sum_next = wclamp(65'(lift_q) + 65'(mres));
		num_next = -wclamp(65'(tmp_q) + 65'(mres));
		tl = 65'(mres);
		lift_mag = MAG_W'(lift_q[63] ? -lift_q : lift_q);
		num_mag = MAG_W'(num_next[63] ? -num_next : num_next);
		div_ge = (rem_q >= dsh_q);
		angle_lim_pos = 14'(alim_q);
		angle_lim_neg = -14'(alim_q);
	end

	// Manual mode clamps.
	logic [27:0] man_thrust;
	logic signed [13:0] man_angle;

	always_comb begin
		if (rh_q < 0) begin
			man_thrust = '0;
		end else if (33'(rh_q) > $signed({5'b0, tlim_q})) begin
			man_thrust = tlim_q;
		end else begin
			man_thrust = 28'(rh_q);
		end
		if (33'(rv_q) > $signed({20'b0, alim_q})) begin
			man_angle = angle_lim_pos;
		end else if (33'(rv_q) < -$signed({20'b0, alim_q})) begin
			man_angle = angle_lim_neg;
		end else begin
			man_angle = 14'(rv_q);
		end
	end

	assign s_axis_tready = (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kp_t_q <= 20'd68813;
			ki_t_q <= 20'd7373;
			kp_a_q <= 20'd9011;
			ki_a_q <= 20'd90;
			period_q <= 16'd3277;
			grav_q <= 20'd40167;
			tlim_q <= 28'd204800000;
			alim_q <= 13'd3215;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_THRUST_KP:  kp_t_q <= cfg_data[19:0];
				REG_THRUST_KI:  ki_t_q <= cfg_data[19:0];
				REG_ANGLE_KP:   kp_a_q <= cfg_data[19:0];
				REG_ANGLE_KI:   ki_a_q <= cfg_data[19:0];
				REG_PERIOD:     period_q <= cfg_data[15:0];
				REG_GRAVITY:    grav_q <= cfg_data[19:0];
				REG_THRUST_LIM: tlim_q <= cfg_data;
				REG_ANGLE_LIM:  alim_q <= cfg_data[12:0];
				default: ;
			endcase
		end
	end

	// Sample registers and datapath temporaries carry no reset.
	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			rh_q <= s_axis_tdata[31:0];
			rv_q <= s_axis_tdata[63:32];
			mass_q <= s_axis_tdata[91:64];
			vh_q <= s_axis_tdata[123:92];
			vv_q <= s_axis_tdata[155:124];
		end
		if (state_q == ST_PREP) begin
			ex_q <= 33'(rh_q) - 33'(vh_q);
			ez_q <= 33'(rv_q) - 33'(vv_q);
		end
		if (state_q == ST_MUL) begin
			if (ph_q == 2'd0) begin
				acc_q <= PROD_W'(mul_p);
			end else if (ph_q == 2'd1) begin
				acc_q <= acc_q + (PROD_W'(mul_p) << 32);
			end
		end
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			mode_q <= 1'b1;
			vsum_q <= '0;
			hsum_q <= '0;
			step_q <= STEP_LIFT;
			ph_q <= 2'd0;
			cnt_q <= '0;
			out_valid_q <= 1'b0;
			lift_q <= '0;
			tmp_q <= '0;
			num_q <= '0;
			den_q <= '0;
			nmag_q <= '0;
			rem_q <= '0;
			dsh_q <= '0;
			quo_q <= '0;
			thrust_q <= '0;
			angle_q <= '0;
			out_thrust_q <= '0;
			out_angle_q <= '0;
			out_auto_q <= 1'b0;
		end else begin
			// While the sequencer delivers, the output register is reloaded instead.
			if (m_axis_tvalid && m_axis_tready && (state_q != ST_DONE)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (s_axis_tvalid) begin
						if (s_axis_tuser == ACT_AUTO_ON) begin
							mode_q <= 1'b1;
						end else if (s_axis_tuser == ACT_AUTO_OFF) begin
							mode_q <= 1'b0;
						end
						state_q <= ST_PREP;
					end
				end
				ST_PREP: begin
					if (mode_q) begin
						vsum_q <= sum_add(vsum_q, 33'(rv_q) - 33'(vv_q));
						hsum_q <= sum_add(hsum_q, 33'(rh_q) - 33'(vh_q));
						step_q <= STEP_LIFT;
						ph_q <= 2'd0;
						state_q <= ST_MUL;
					end else begin
						thrust_q <= man_thrust;
						angle_q <= man_angle;
						if (man_thrust == '0) begin
							vsum_q <= '0;
						end
						state_q <= ST_DONE;
					end
				end
				ST_MUL: begin
					if (ph_q != 2'd2) begin
						ph_q <= ph_q + 2'd1;
					end else begin
						ph_q <= 2'd0;
						step_q <= step_q + 3'd1;
						case (step_q)
							STEP_LIFT: begin
								lift_q <= wclamp(65'(mres) - 65'(grav_q));
							end
							STEP_VINT: begin
								tmp_q <= mres;
							end
							STEP_PERIOD: begin
								tmp_q <= sum_next;
							end
							STEP_MASS: begin
								// Thrust clamp; zero thrust resets the vertical sum.
								if (tl <= 0) begin
									thrust_q <= '0;
									vsum_q <= '0;
								end else if (tl > $signed({37'b0, tlim_q})) begin
									thrust_q <= tlim_q;
									if (tlim_q == '0) begin
										vsum_q <= '0;
									end
								end else begin
									thrust_q <= 28'(mres);
								end
							end
							STEP_APROP: begin
								tmp_q <= mres;
							end
							STEP_AINT: begin
								num_q <= num_next;
								nmag_q <= num_mag;
								den_q <= lift_mag;
								if (lift_mag == '0) begin
									// Zero divisor saturates toward the numerator sign.
									if (num_next > 0) begin
										angle_q <= angle_lim_pos;
									end else if (num_next < 0) begin
										angle_q <= angle_lim_neg;
									end else begin
										angle_q <= '0;
									end
									hsum_q <= '0;
									state_q <= ST_DONE;
								end
							end
							STEP_RANGE: begin
								// Integer quotient above the limit saturates at once.
								if (PROD_W'(nmag_q) >= acc_q) begin
									angle_q <= num_q[63] ? angle_lim_neg : angle_lim_pos;
									hsum_q <= '0;
									state_q <= ST_DONE;
								end else begin
									rem_q <= DIV_W'(nmag_q) << FRAC_BITS;
									dsh_q <= DIV_W'(den_q) << (QB - 1);
									quo_q <= '0;
									cnt_q <= CNT_W'(QB - 1);
									state_q <= ST_DIV;
								end
							end
							default: ;
						endcase
					end
				end
				ST_DIV: begin
					if (div_ge) begin
						rem_q <= rem_q - dsh_q;
					end
					quo_q <= {quo_q[QB-2:0], div_ge};
					dsh_q <= dsh_q >> 1;
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == '0) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (quo_q > QB'(alim_q)) begin
						angle_q <= num_q[63] ? angle_lim_neg : angle_lim_pos;
						hsum_q <= '0;
					end else begin
						angle_q <= num_q[63] ? -14'(quo_q) : 14'(quo_q);
					end
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (!out_valid_q || m_axis_tready) begin
						out_valid_q <= 1'b1;
						out_thrust_q <= thrust_q;
						out_angle_q <= angle_q;
						out_auto_q <= mode_q;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata = {6'b0, out_angle_q, out_thrust_q};
	assign m_axis_tuser = out_auto_q;

	// An accepted sample always starts the sequencer.
	assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) |=> (state_q == ST_PREP))
		else $error("accepted sample did not start the sequencer");

	// A delivered result never exceeds the thrust limit.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (out_thrust_q <= tlim_q))
		else $error("thrust result beyond limit");

	// A delivered angle stays within the angle limit.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> ($signed(out_angle_q) <= $signed({1'b0, alim_q}) &&
			$signed(out_angle_q) >= -$signed({1'b0, alim_q})))
		else $error("angle result beyond limit");

	// The divider only runs on a nonzero divisor.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (den_q != '0))
		else $error("divider running on zero divisor");

endmodule
